### rtl/fflk_pkg.sv
// Shared types, codes and defaults for the fair FIFO reader/writer lock manager.
// Used by every module under rtl; depends on nothing.
package fflk_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int ID_BITS_DEF     = 8;
  localparam int WHO_W           = 8;
  // A release passes at most this many queued readers to the lock.
  localparam int MAX_GRANTS      = 32;

  typedef enum logic [2:0] {
    EV_GRANT    = 3'd0,
    EV_QUEUED   = 3'd1,
    EV_REJECT   = 3'd2,
    EV_QGRANT   = 3'd3,
    EV_RELEASED = 3'd4,
    EV_RELERR   = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    CMD_ACQ_RD = 2'd0,
    CMD_ACQ_WR = 2'd1,
    CMD_REL_RD = 2'd2,
    CMD_REL_WR = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    logic             func;
    logic             reader_kind;
    logic [WHO_W-1:0] requester;
  } req_t;

  typedef struct packed {
    event_t           event_res;
    logic [WHO_W-1:0] who;
    logic             shared;
    logic             last;
  } res_t;

endpackage

### rtl/fflk_front.sv
// Front stage: registers an incoming request beat and decodes it into a command.
// Depends on fflk_pkg; feeds fflk_cmd_queue.
module fflk_front import fflk_pkg::*; #(
  parameter int ID_BITS = ID_BITS_DEF,
  localparam int CMD_W  = ID_BITS + 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             push_valid,
  output logic [CMD_W-1:0] push_data,
  input  logic             push_full
);

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ID_BITS-1:0] id;
  } cmd_t;

  logic                     cmd_valid;
  cmd_t                     cmd;
  cmd_t                     cmd_next;
  logic [ID_BITS+WHO_W-1:0] req_ext;

  assign req_ext = {{ID_BITS{1'b0}}, req.requester};

  always_comb begin
    cmd_next.id = req_ext[ID_BITS-1:0];
    if (req.func) begin
      cmd_next.kind = req.reader_kind ? CMD_REL_RD : CMD_REL_WR;
    end else begin
      cmd_next.kind = req.reader_kind ? CMD_ACQ_RD : CMD_ACQ_WR;
    end
  end

  assign req_stall  = cmd_valid && push_full;
  assign push_valid = cmd_valid;
  assign push_data  = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      cmd_valid <= 1'b1;
    end else if (!push_full) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      cmd <= cmd_next;
    end
  end

endmodule

### rtl/fflk_cmd_queue.sv
// Two-entry command queue between the decode front and the lock back end.
// Depends on fflk_pkg for the default of WIDTH (ID_BITS_DEF).
module fflk_cmd_queue import fflk_pkg::*; #(
  parameter int WIDTH = ID_BITS_DEF + 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_full,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign push_full = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data  = slots[rd_ptr];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/fflk_back.sv
// Back end: lock state, ring of waiters in a memory, grant sequencer, result register.
// Depends on fflk_pkg; takes commands from fflk_cmd_queue.
module fflk_back import fflk_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  localparam int CMD_W      = ID_BITS + 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop,
  input  logic [CMD_W-1:0] pop_data,
  output logic             res_valid,
  input  logic             res_stall,
  output res_t             res
);

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int GRANT_W = $clog2(MAX_GRANTS);

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ID_BITS-1:0] id;
  } cmd_t;

  typedef struct packed {
    logic               rd;
    logic [ID_BITS-1:0] id;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_GRANT
  } state_t;

  state_t             state;
  cmd_t               cur;
  entry_t             ring [QUEUE_DEPTH];
  entry_t             head_entry;
  entry_t             after_entry;
  logic [IDX_W-1:0]   ring_head;
  logic [IDX_W-1:0]   ring_head_next;
  logic [IDX_W-1:0]   ring_tail;
  logic [CNT_W-1:0]   readers_waiting;
  logic [CNT_W-1:0]   writers_waiting;
  logic [7:0]         readers_holding;
  logic               writer_holding;
  logic [GRANT_W-1:0] grants;
  logic [SUM_W-1:0]   waiting_total;
  logic               ring_full;
  logic               out_free;
  logic               advance;
  logic               ring_we;
  entry_t             ring_wdata;
  logic               handoff;
  logic               res_load;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
    return (p == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + IDX_W'(1);
  endfunction

  function automatic logic [WHO_W-1:0] to_who(input logic [ID_BITS-1:0] v);
    logic [ID_BITS+WHO_W-1:0] ext;
    ext = {{WHO_W{1'b0}}, v};
    return ext[WHO_W-1:0];
  endfunction

  assign waiting_total = {1'b0, readers_waiting} + {1'b0, writers_waiting};
  assign ring_full     = (waiting_total >= SUM_W'(QUEUE_DEPTH));
  assign out_free      = !res_valid || !res_stall;
  assign pop           = (state == S_IDLE) && pop_valid;
  assign res_load      = ((state == S_EXEC) || (state == S_GRANT)) && out_free;

  // The last holder leaving with waiters behind hands the lock on.
  assign handoff = (((cur.kind == CMD_REL_RD) && (readers_holding == 8'd1) && !writer_holding) ||
                    ((cur.kind == CMD_REL_WR) && writer_holding && (readers_holding == 8'd0))) &&
                   (waiting_total != '0);

  // The head pointer moves only while granting from the ring. Both read ports
  // look at the coming head and are registered, so head_entry and after_entry follow it.
  assign advance        = (state == S_GRANT) && out_free;
  assign ring_head_next = advance ? ring_next(ring_head) : ring_head;

  always_comb begin
    ring_we    = 1'b0;
    ring_wdata = '{rd: 1'b0, id: cur.id};
    if (state == S_EXEC && out_free && !ring_full) begin
      if (cur.kind == CMD_ACQ_RD) begin
        ring_wdata.rd = 1'b1;
        ring_we       = writer_holding || (writers_waiting != '0);
      end else if (cur.kind == CMD_ACQ_WR) begin
        ring_we = writer_holding || (readers_holding != 8'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_tail] <= ring_wdata;
    end
    head_entry  <= ring[ring_head_next];
    after_entry <= ring[ring_next(ring_head_next)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      ring_head       <= '0;
      ring_tail       <= '0;
      readers_waiting <= '0;
      writers_waiting <= '0;
      readers_holding <= 8'd0;
      writer_holding  <= 1'b0;
      grants          <= '0;
      res_valid       <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      ring_head <= ring_head_next;
      if (ring_we) begin
        ring_tail <= ring_next(ring_tail);
      end
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            cur   <= cmd_t'(pop_data);
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            res.who       <= to_who(cur.id);
            res.shared    <= (cur.kind == CMD_ACQ_RD) || (cur.kind == CMD_REL_RD);
            res.last      <= !handoff;
            grants        <= '0;
            state         <= handoff ? S_GRANT : S_IDLE;
            unique case (cur.kind)
              CMD_ACQ_RD: begin
                if (ring_full) begin
                  res.event_res <= EV_REJECT;
                end else if (!writer_holding && writers_waiting == '0) begin
                  if (readers_holding == 8'hFF) begin
                    res.event_res <= EV_REJECT;
                  end else begin
                    readers_holding <= readers_holding + 8'd1;
                    res.event_res   <= EV_GRANT;
                  end
                end else begin
                  readers_waiting <= readers_waiting + CNT_W'(1);
                  res.event_res   <= EV_QUEUED;
                end
              end
              CMD_ACQ_WR: begin
                if (ring_full) begin
                  res.event_res <= EV_REJECT;
                end else if (!writer_holding && readers_holding == 8'd0) begin
                  writer_holding <= 1'b1;
                  res.event_res  <= EV_GRANT;
                end else begin
                  writers_waiting <= writers_waiting + CNT_W'(1);
                  res.event_res   <= EV_QUEUED;
                end
              end
              CMD_REL_RD: begin
                if (readers_holding == 8'd0) begin
                  res.event_res <= EV_RELERR;
                end else begin
                  readers_holding <= readers_holding - 8'd1;
                  res.event_res   <= EV_RELEASED;
                end
              end
              CMD_REL_WR: begin
                if (!writer_holding) begin
                  res.event_res <= EV_RELERR;
                end else begin
                  writer_holding <= 1'b0;
                  res.event_res  <= EV_RELEASED;
                end
              end
              default: begin
                res.event_res <= EV_RELERR;
              end
            endcase
          end
        end
        S_GRANT: begin
          if (out_free) begin
            res.event_res <= EV_QGRANT;
            res.who       <= to_who(head_entry.id);
            res.shared    <= head_entry.rd;
            if (!head_entry.rd) begin
              writer_holding  <= 1'b1;
              writers_waiting <= writers_waiting - CNT_W'(1);
              res.last        <= 1'b1;
              state           <= S_IDLE;
            end else begin
              readers_waiting <= readers_waiting - CNT_W'(1);
              readers_holding <= readers_holding + 8'd1;
              grants          <= grants + GRANT_W'(1);
              // The run of readers ends at a writer, at the last reader waiting,
              // or when the beat count for one release is used up.
              if (readers_waiting == CNT_W'(1) || !after_entry.rd ||
                  grants == GRANT_W'(MAX_GRANTS - 1)) begin
                res.last <= 1'b1;
                state    <= S_IDLE;
              end else begin
                res.last <= 1'b0;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/fifo_fair_reader_writer_lock.sv
// Top level of the fair FIFO reader/writer lock manager.
// Depends on fflk_pkg, fflk_front, fflk_cmd_queue and fflk_back.
//
// Usage:
//   The req channel takes one acquire or release beat (func, reader_kind,
//   requester) per handshake; a beat is taken when req_valid is high and
//   req_stall is low. The res channel returns result beats (event_res, who,
//   shared, last) under the same valid/stall rule; last marks the final
//   beat caused by one request.
//   An acquire gives one beat. A release gives a released or error beat,
//   then one queued-grant beat per waiter handed the lock, in ring order.
//   A request beat is held in the front register, the command queue and the
//   back end's command register before its first result beat is loaded.
//   The back end takes a new command only when idle; a release grants its
//   queued waiters one per cycle from the ring memory while res_stall is low.
//   Reset: the lock is free and the ring empty; no clearing pass is needed,
//   so requests are taken as soon as reset is released.
//   When res_stall is high the result register holds its beat and the back
//   end waits; the two-entry command queue and the front register then fill
//   and req_stall rises.
module fifo_fair_reader_writer_lock import fflk_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int CMD_W = ID_BITS + 2;

  logic             push_valid;
  logic [CMD_W-1:0] push_data;
  logic             push_full;
  logic             pop_valid;
  logic             pop;
  logic [CMD_W-1:0] pop_data;

  fflk_front #(
    .ID_BITS (ID_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_full  (push_full)
  );

  fflk_cmd_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_full  (push_full),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  fflk_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_data  (pop_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
